@@ hdl/hgli_pkg.sv @@
// ----------------------------------------------------------------------------
// hgli_pkg: shared types and constants of the hold-gap linear interpolator
// Item formats, arithmetic unit request/response, sequencer state codes.
// ----------------------------------------------------------------------------
`default_nettype none

package hgli_pkg;

  localparam int unsigned DATA_W              = 32;
  // Span magnitudes: difference of two 32-bit values, as unsigned
  localparam int unsigned MAG_W               = DATA_W + 1;
  // Full product of two span magnitudes
  localparam int unsigned PROD_W              = 2 * MAG_W;
  // Multiplier operand split: low part of the second operand
  localparam int unsigned MUL_SPLIT           = 17;
  localparam int unsigned DIV_CNT_W           = $clog2(PROD_W);
  localparam int unsigned HOLD_DEPTH_DEF      = 32;
  localparam int unsigned VALUE_FRAC_BITS_DEF = 16;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample_time;
    logic signed [DATA_W-1:0] sample_value;
    logic                     end_of_stream;
  } sample_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_time;
    logic signed [DATA_W-1:0] out_value;
    logic                     was_interpolated;
    logic                     buffer_overflow;
    logic                     run_last;
  } result_t;

  // Request to the multiply-divide unit: quot = mul_a * mul_b / divisor
  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] mul_a;
    logic [MAG_W-1:0] mul_b;
    logic [MAG_W-1:0] divisor;
  } md_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] quot;
  } md_rsp_t;

  typedef enum logic [2:0] {
    MD_IDLE,
    MD_MUL_LO,
    MD_MUL_HI,
    MD_DIV,
    MD_DONE
  } md_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_PREP,
    ST_WAIT,
    ST_EMIT_HELD,
    ST_EMIT_OWN,
    ST_EMIT_OVF
  } seq_state_t;

  // Unsigned magnitude of a signed span
  function automatic logic [MAG_W-1:0] span_mag(input logic signed [MAG_W-1:0] x);
    logic [MAG_W-1:0] u;
    u = x;
    return x[MAG_W-1] ? (~u + {{(MAG_W-1){1'b0}}, 1'b1}) : u;
  endfunction

endpackage

`default_nettype wire

@@ hdl/hgli_chan_if.sv @@
// ----------------------------------------------------------------------------
// hgli_chan_if: valid/ready channel
// One item moves at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface hgli_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hdl/hgli_muldiv.sv @@
// ----------------------------------------------------------------------------
// hgli_muldiv: shared multiply-divide unit
// Split multiply, low part then high part, then one quotient bit per cycle (restoring).
// ----------------------------------------------------------------------------
`default_nettype none

module hgli_muldiv (
  input  logic              clk,
  input  logic              rst_n,
  input  hgli_pkg::md_req_t req,
  output hgli_pkg::md_rsp_t rsp
);

  localparam int unsigned MAG_W  = hgli_pkg::MAG_W;
  localparam int unsigned PROD_W = hgli_pkg::PROD_W;
  localparam int unsigned SPLIT  = hgli_pkg::MUL_SPLIT;
  localparam int unsigned CNT_W  = hgli_pkg::DIV_CNT_W;
  localparam int unsigned MP_W   = MAG_W + SPLIT;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(PROD_W - 1);

  hgli_pkg::md_state_t state_r, state_nxt;

  logic [MAG_W-1:0]  a_r, b_r, d_r;
  logic [MAG_W-1:0]  rem_r;
  logic [PROD_W-1:0] prod_r;   // product, then dividend shifting out / quotient in
  logic [CNT_W-1:0]  cnt_r;

  logic [SPLIT-1:0]  mul_b_part;
  logic [MP_W-1:0]   mul_p;
  logic [MAG_W:0]    rem_sh;
  logic [MAG_W:0]    rem_diff;
  logic              rem_ge;
  logic [MAG_W-1:0]  rem_nxt;

  assign mul_b_part = (state_r == hgli_pkg::MD_MUL_HI)
                    ? SPLIT'(b_r[MAG_W-1:SPLIT]) : b_r[SPLIT-1:0];
  assign mul_p      = a_r * mul_b_part;

  assign rem_sh   = {rem_r, prod_r[PROD_W-1]};
  assign rem_diff = rem_sh - {1'b0, d_r};
  assign rem_ge   = (rem_sh >= {1'b0, d_r});
  assign rem_nxt  = rem_ge ? rem_diff[MAG_W-1:0] : rem_sh[MAG_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hgli_pkg::MD_IDLE:   if (req.start) state_nxt = hgli_pkg::MD_MUL_LO;
      hgli_pkg::MD_MUL_LO: state_nxt = hgli_pkg::MD_MUL_HI;
      hgli_pkg::MD_MUL_HI: state_nxt = hgli_pkg::MD_DIV;
      hgli_pkg::MD_DIV:    if (cnt_r == LAST_STEP) state_nxt = hgli_pkg::MD_DONE;
      hgli_pkg::MD_DONE:   state_nxt = hgli_pkg::MD_IDLE;
      default:             state_nxt = hgli_pkg::MD_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rsp.done = (state_r == hgli_pkg::MD_DONE);
    rsp.quot = prod_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hgli_pkg::MD_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      hgli_pkg::MD_IDLE: begin
        if (req.start) begin
          a_r <= req.mul_a;
          b_r <= req.mul_b;
          d_r <= req.divisor;
        end
      end
      hgli_pkg::MD_MUL_LO: begin
        prod_r <= PROD_W'(mul_p);
        rem_r  <= '0;
        cnt_r  <= '0;
      end
      hgli_pkg::MD_MUL_HI: begin
        prod_r <= prod_r + (PROD_W'(mul_p) << SPLIT);
      end
      hgli_pkg::MD_DIV: begin
        prod_r <= {prod_r[PROD_W-2:0], rem_ge};
        rem_r  <= rem_nxt;
        cnt_r  <= cnt_r + CNT_W'(1);
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/hold_gap_linear_interpolator.sv @@
// ----------------------------------------------------------------------------
// hold_gap_linear_interpolator: fills held gaps of a slowly updating signal
// Repeated samples are buffered by time, then emitted with interpolated values.
// ----------------------------------------------------------------------------
// A sample whose value equals the current anchor value (and is not marked end
// of stream) is held: its time goes into a HOLD_DEPTH-entry buffer and no item
// comes out, and the block stays ready for the next sample.
// A distinct sample, or one marked end of stream, emits one item per buffered
// time, in order, valued va + trunc((v - va) * (h - ta) / (t - ta)) saturated
// to 32 bits, then the sample itself (run_last set); it becomes the new anchor.
// Each buffered time passes through a memory read, a setup step, a split
// multiply and a 66-step restoring divide in the shared multiply-divide unit,
// and an output step that waits for a free output register. A zero time span
// skips the multiply and the divide. No new item is taken during a run.
// A repeat arriving with the buffer full is emitted alone with buffer_overflow
// set. The anchor resets to time -1 and value -1.0; the buffer needs no clear.
// A single output register holds the last item, so a new sample can be taken
// while the final item of a run still waits for the sink.
// ----------------------------------------------------------------------------
`default_nettype none

module hold_gap_linear_interpolator #(
  parameter int unsigned HOLD_DEPTH      = hgli_pkg::HOLD_DEPTH_DEF,
  parameter int unsigned VALUE_FRAC_BITS = hgli_pkg::VALUE_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  hgli_chan_if.sink   in_ch,
  hgli_chan_if.source out_ch
);

  localparam int unsigned DATA_W = hgli_pkg::DATA_W;
  localparam int unsigned MAG_W  = hgli_pkg::MAG_W;
  localparam int unsigned PROD_W = hgli_pkg::PROD_W;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned CNT_W  = $clog2(HOLD_DEPTH + 1);
  localparam int unsigned IDX_W  = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(HOLD_DEPTH);
  // -1.0 in the value format: ~(2^frac - 1)
  localparam logic [DATA_W-1:0] ANCHOR_VALUE_RST =
    ~((DATA_W'(1) << VALUE_FRAC_BITS) - DATA_W'(1));
  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  hgli_pkg::seq_state_t state_r, state_nxt;

  // anchor (last distinct point) and the sample being worked on
  logic signed [DATA_W-1:0] anchor_time_r, anchor_value_r;
  logic signed [DATA_W-1:0] smp_time_r, smp_value_r;

  // held times
  logic [DATA_W-1:0]        held_mem [HOLD_DEPTH];
  logic [DATA_W-1:0]        rd_data_r;
  logic [CNT_W-1:0]         held_count_r;
  logic [CNT_W-1:0]         idx_r;

  // per held time
  logic signed [MAG_W-1:0]  dt_r, dv_r;
  logic signed [MAG_W-1:0]  dh;
  logic signed [DATA_W-1:0] hold_time_r;
  logic                     neg_r;
  logic                     zero_dt_r;

  hgli_pkg::md_req_t        md_req;
  hgli_pkg::md_rsp_t        md_rsp;

  // output register
  logic                     out_valid_r;
  hgli_pkg::result_t        out_data_r;
  hgli_pkg::result_t        result_c;

  logic                     in_fire;
  logic                     in_distinct;
  logic                     room;
  logic                     slot_free;
  logic                     last_idx;
  logic                     in_ready_c;
  logic                     mem_we;
  logic                     out_load;

  logic [SUM_W-1:0]         anchor_ext;
  logic [SUM_W-1:0]         quot_ext;
  logic [SUM_W-1:0]         interp_sum;
  logic                     sum_fits;
  logic [DATA_W-1:0]        interp_sat;
  logic signed [DATA_W-1:0] held_value;

  assign in_fire     = in_ch.valid && in_ready_c;
  assign in_distinct = (in_ch.payload.sample_value != anchor_value_r)
                    || in_ch.payload.end_of_stream;
  assign room        = (held_count_r < DEPTH_CNT);
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign last_idx    = ((idx_r + CNT_W'(1)) == held_count_r);

  // read port data is valid from the setup cycle on and holds until the index advances
  assign dh = {rd_data_r[DATA_W-1], rd_data_r} - {anchor_time_r[DATA_W-1], anchor_time_r};

  // va +/- quotient, then saturate to 32 bits
  assign anchor_ext = SUM_W'(anchor_value_r);
  assign quot_ext   = {1'b0, md_rsp.quot};
  assign interp_sum = neg_r ? (anchor_ext - quot_ext) : (anchor_ext + quot_ext);
  assign sum_fits   = (interp_sum[SUM_W-1:DATA_W-1] == '0)
                   || (interp_sum[SUM_W-1:DATA_W-1] == '1);
  assign interp_sat = sum_fits ? interp_sum[DATA_W-1:0]
                    : (interp_sum[SUM_W-1] ? SAT_MIN : SAT_MAX);
  // a zero time span keeps the anchor value
  assign held_value = zero_dt_r ? anchor_value_r : interp_sat;

  // shared multiply-divide unit
  hgli_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .rsp   (md_rsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hgli_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_distinct) begin
            state_nxt = (held_count_r == '0) ? hgli_pkg::ST_EMIT_OWN : hgli_pkg::ST_READ;
          end else if (!room) begin
            state_nxt = hgli_pkg::ST_EMIT_OVF;
          end
        end
      end
      hgli_pkg::ST_READ: state_nxt = hgli_pkg::ST_PREP;
      hgli_pkg::ST_PREP: begin
        state_nxt = (dt_r == '0) ? hgli_pkg::ST_EMIT_HELD : hgli_pkg::ST_WAIT;
      end
      hgli_pkg::ST_WAIT: begin
        if (md_rsp.done) state_nxt = hgli_pkg::ST_EMIT_HELD;
      end
      hgli_pkg::ST_EMIT_HELD: begin
        if (slot_free) state_nxt = last_idx ? hgli_pkg::ST_EMIT_OWN : hgli_pkg::ST_READ;
      end
      hgli_pkg::ST_EMIT_OWN,
      hgli_pkg::ST_EMIT_OVF: begin
        if (slot_free) state_nxt = hgli_pkg::ST_IDLE;
      end
      default: state_nxt = hgli_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_c     = 1'b0;
    mem_we         = 1'b0;
    out_load       = 1'b0;
    md_req.start   = 1'b0;
    md_req.mul_a   = hgli_pkg::span_mag(dv_r);
    md_req.mul_b   = hgli_pkg::span_mag(dh);
    md_req.divisor = hgli_pkg::span_mag(dt_r);
    result_c.out_time         = smp_time_r;
    result_c.out_value        = smp_value_r;
    result_c.was_interpolated = 1'b0;
    result_c.buffer_overflow  = 1'b0;
    result_c.run_last         = 1'b1;
    unique case (state_r)
      hgli_pkg::ST_IDLE: begin
        in_ready_c = 1'b1;
        mem_we     = in_ch.valid && !in_distinct && room;
      end
      hgli_pkg::ST_PREP: begin
        md_req.start = (dt_r != '0);
      end
      hgli_pkg::ST_EMIT_HELD: begin
        out_load                  = slot_free;
        result_c.out_time         = hold_time_r;
        result_c.out_value        = held_value;
        result_c.was_interpolated = 1'b1;
        result_c.run_last         = 1'b0;
      end
      hgli_pkg::ST_EMIT_OWN: begin
        out_load = slot_free;
      end
      hgli_pkg::ST_EMIT_OVF: begin
        out_load                 = slot_free;
        result_c.buffer_overflow = 1'b1;
      end
      hgli_pkg::ST_READ,
      hgli_pkg::ST_WAIT: ;
      default: ;
    endcase
  end

  assign in_ch.ready    = in_ready_c;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_data_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= hgli_pkg::ST_IDLE;
      anchor_time_r  <= '1;
      anchor_value_r <= ANCHOR_VALUE_RST;
      held_count_r   <= '0;
      idx_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (mem_we) begin
        held_count_r <= held_count_r + CNT_W'(1);
      end
      if (in_fire) begin
        idx_r <= '0;
      end else if (state_r == hgli_pkg::ST_EMIT_HELD && slot_free) begin
        idx_r <= idx_r + CNT_W'(1);
      end
      // own sample emitted: it becomes the anchor, buffer empties
      if (state_r == hgli_pkg::ST_EMIT_OWN && slot_free) begin
        anchor_time_r  <= smp_time_r;
        anchor_value_r <= smp_value_r;
        held_count_r   <= '0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      smp_time_r  <= in_ch.payload.sample_time;
      smp_value_r <= in_ch.payload.sample_value;
    end
    if (state_r == hgli_pkg::ST_READ) begin
      dt_r <= {smp_time_r[DATA_W-1], smp_time_r}
            - {anchor_time_r[DATA_W-1], anchor_time_r};
      dv_r <= {smp_value_r[DATA_W-1], smp_value_r}
            - {anchor_value_r[DATA_W-1], anchor_value_r};
    end
    if (state_r == hgli_pkg::ST_PREP) begin
      neg_r     <= dv_r[MAG_W-1] ^ dh[MAG_W-1] ^ dt_r[MAG_W-1];
      zero_dt_r <= (dt_r == '0);
    end
    if (out_load) begin
      out_data_r <= result_c;
    end
  end

  // hold time taken from the read port in the setup state
  always_ff @(posedge clk) begin
    if (state_r == hgli_pkg::ST_PREP) begin
      hold_time_r <= rd_data_r;
    end
  end

  // held-time memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      held_mem[held_count_r[IDX_W-1:0]] <= in_ch.payload.sample_time;
    end
    rd_data_r <= held_mem[idx_r[IDX_W-1:0]];
  end

endmodule

`default_nettype wire

@@ hdl/hgli_checker.sv @@
// ----------------------------------------------------------------------------
// hgli_checker: port-level checks of the hold-gap linear interpolator
// Bound to the top level; watches only its channel ports.
// ----------------------------------------------------------------------------
`default_nettype none

module hgli_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input hgli_pkg::result_t out_payload
);

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("stalled result changed");

  // an overflow item stands alone and is not interpolated
  a_ovf_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.buffer_overflow |->
      out_payload.run_last && !out_payload.was_interpolated)
    else $error("overflow item not a lone final item");

  // an interpolated item never closes a run
  a_interp_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.was_interpolated |-> !out_payload.run_last)
    else $error("interpolated item flagged last");

  // mid-run the block takes no new sample
  a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload.run_last |-> !in_ready)
    else $error("input taken during a run");

endmodule

bind hold_gap_linear_interpolator hgli_checker u_hgli_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_payload (out_ch.payload)
);

`default_nettype wire

@@ sim/tb_hold_gap_linear_interpolator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hold_gap_linear_interpolator: self-checking bench for the gap interpolator
// Drives (time, value, end_of_stream) samples through the valid/ready input,
// predicts every emitted point (held times with interpolated values, own
// samples, overflow repeats) and checks each output item in order.
// ----------------------------------------------------------------------------

module tb_hold_gap_linear_interpolator;

  localparam int unsigned DEPTH           = hgli_pkg::HOLD_DEPTH_DEF;
  localparam int unsigned FRAC            = hgli_pkg::VALUE_FRAC_BITS_DEF;
  localparam int unsigned ITEM_TARGET     = 320;
  localparam int unsigned PRESSURE_CYCLES = 600;
  // Worst quiet stretch: long sink hold-off + per-point work + long sender gaps
  localparam int unsigned WATCHDOG_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES    = 200;
  localparam int unsigned PRINT_LIMIT     = 40;

  localparam logic signed [31:0]  S32_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0]  S32_MIN   = 32'sh8000_0000;
  localparam logic signed [31:0]  RESET_T   = -32'sd1;
  localparam logic signed [31:0]  RESET_V   = -(32'sd1 <<< FRAC);
  localparam logic signed [127:0] WIDE_MAX  = 128'sh7FFF_FFFF;
  localparam logic signed [127:0] WIDE_MIN  = -128'sh8000_0000;

  logic clk = 1'b0;
  logic rst_n;

  always #5 clk = ~clk;

  hgli_chan_if #(.payload_t(hgli_pkg::sample_t)) in_ch ();
  hgli_chan_if #(.payload_t(hgli_pkg::result_t)) out_ch ();

  hold_gap_linear_interpolator u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // --------------------------------------------------------------------------
  // Interpolator state as the bench sees it
  // --------------------------------------------------------------------------
  logic signed [31:0] anchor_t;
  logic signed [31:0] anchor_v;
  logic signed [31:0] held_stamp [DEPTH];
  int unsigned        held_n;

  // Points the block still owes us, oldest first
  hgli_pkg::result_t due_points [$];

  // Bookkeeping
  int unsigned error_count;
  int unsigned samples_sent;
  int unsigned points_checked;
  int unsigned interp_points;
  int unsigned overflow_points;
  int unsigned clipped_points;
  int unsigned zero_span_runs;
  int unsigned eos_flushes;
  int unsigned quiet_cycles;

  // Stimulus knobs shared between processes
  logic signed [31:0] stamp;          // running sample time
  bit                 src_gapless;    // sender never idles while set
  int unsigned        hold_off_len;   // long sink hold-off request
  bit                 sink_holding;   // sink is inside the hold-off

  task automatic report_mismatch(input string what);
    if (error_count < PRINT_LIMIT)
      $display("[%0t] ERROR %s", $time, what);
    error_count++;
  endtask

  task automatic clear_interpolator();
    anchor_t = RESET_T;
    anchor_v = RESET_V;
    held_n   = 0;
  endtask

  function automatic logic [127:0] span_magnitude(input logic signed [33:0] x);
    logic [127:0] w;
    w = {{94{x[33]}}, x};
    return x[33] ? -w : w;
  endfunction

  // va + trunc((v - va) * (h - ta) / (t - ta)), saturated to 32 bits.
  // Spans are 34-bit signed, the product is kept exact in 128 bits.
  function automatic logic signed [31:0] interp_point(
      input  logic signed [31:0] h,
      input  logic signed [31:0] t,
      input  logic signed [31:0] v,
      output bit                 clipped);
    logic signed [33:0]  dv, dh, dt;
    logic [127:0]        quo;
    logic signed [127:0] sum;
    bit                  neg;
    clipped = 1'b0;
    dv = {{2{v[31]}}, v} - {{2{anchor_v[31]}}, anchor_v};
    dh = {{2{h[31]}}, h} - {{2{anchor_t[31]}}, anchor_t};
    dt = {{2{t[31]}}, t} - {{2{anchor_t[31]}}, anchor_t};
    if (dt == 0)
      return anchor_v;          // zero span: hold the anchor value
    neg = dv[33] ^ dh[33] ^ dt[33];
    quo = (span_magnitude(dv) * span_magnitude(dh)) / span_magnitude(dt);
    sum = {{96{anchor_v[31]}}, anchor_v};
    if (neg) sum = sum - $signed(quo);
    else     sum = sum + $signed(quo);
    if (sum > WIDE_MAX) begin
      clipped = 1'b1;
      return S32_MAX;
    end
    if (sum < WIDE_MIN) begin
      clipped = 1'b1;
      return S32_MIN;
    end
    return sum[31:0];
  endfunction

  task automatic queue_point(input logic signed [31:0] t, input logic signed [31:0] v,
                             input bit interp, input bit ovf, input bit last);
    hgli_pkg::result_t p;
    p.out_time         = t;
    p.out_value        = v;
    p.was_interpolated = interp;
    p.buffer_overflow  = ovf;
    p.run_last         = last;
    due_points = {due_points, p};
  endtask

  // Applies one accepted sample: either holds its time, flushes the held
  // times plus the sample itself, or emits an overflow repeat.
  task automatic interpolate_and_hold(input hgli_pkg::sample_t s);
    logic signed [31:0] v_hat;
    bit                 clipped;
    if (s.sample_value != anchor_v || s.end_of_stream) begin
      if (s.end_of_stream) eos_flushes++;
      if (held_n != 0 && s.sample_time == anchor_t) zero_span_runs++;
      for (int unsigned i = 0; i < held_n; i++) begin
        v_hat = interp_point(held_stamp[i], s.sample_time, s.sample_value, clipped);
        if (clipped) clipped_points++;
        interp_points++;
        queue_point(held_stamp[i], v_hat, 1'b1, 1'b0, 1'b0);
      end
      held_n = 0;
      queue_point(s.sample_time, s.sample_value, 1'b0, 1'b0, 1'b1);
      anchor_t = s.sample_time;
      anchor_v = s.sample_value;
    end else if (held_n < DEPTH) begin
      held_stamp[held_n] = s.sample_time;
      held_n++;
    end else begin
      overflow_points++;
      queue_point(s.sample_time, s.sample_value, 1'b0, 1'b1, 1'b1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Random helpers
  // --------------------------------------------------------------------------
  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (src_gapless) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic signed [31:0] random_value();
    int unsigned r;
    logic [31:0] u;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      u = $urandom_range(0, 32'h1F_FFFF);
      return $signed(u - 32'h10_0000);
    end
    if (r < 75) return $signed($urandom());
    if (r < 85) begin
      case ($urandom_range(0, 3))
        0:       return S32_MAX;
        1:       return S32_MIN;
        2:       return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return anchor_v + $signed(32'($urandom_range(0, 16))) - 32'sd8;
  endfunction

  function automatic logic signed [31:0] distinct_value();
    logic signed [31:0] v;
    v = random_value();
    return (v == anchor_v) ? (v ^ 32'sd1) : v;
  endfunction

  // Advances the running time; now and then it jumps anywhere, which also
  // makes times go backwards or wrap
  function automatic logic signed [31:0] next_stamp();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70)      stamp = stamp + $signed(32'($urandom_range(1, 64)));
    else if (r < 95) stamp = stamp + $signed(32'($urandom_range(65, 100000)));
    else             stamp = $signed($urandom());
    return stamp;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: one item per call. valid stays high into the next call when
  // there is no gap, so it is never lowered and raised in one time step.
  // --------------------------------------------------------------------------
  task automatic send_sample(input logic signed [31:0] t, input logic signed [31:0] v,
                             input bit eos);
    int unsigned       gap;
    hgli_pkg::sample_t s;
    gap             = pick_gap();
    s.sample_time   = t;
    s.sample_value  = v;
    s.end_of_stream = eos;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    interpolate_and_hold(s);
    samples_sent++;
  endtask

  // --------------------------------------------------------------------------
  // Sink pacing: alternating flow and stall stretches, plus the long
  // hold-off on request, counted here cycle by cycle.
  // --------------------------------------------------------------------------
  initial begin : sink_pacing
    int unsigned seg;
    int unsigned r;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_len != 0) begin
        seg          = hold_off_len;
        sink_holding = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (seg) @(posedge clk);
        hold_off_len = 0;
        sink_holding = 1'b0;
      end else begin
        seg = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                          : $urandom_range(1, 20);
        out_ch.ready <= 1'b1;
        repeat (seg) @(posedge clk);
        r = $urandom_range(0, 99);
        if (r < 70)      seg = $urandom_range(1, 3);
        else if (r < 95) seg = $urandom_range(4, 12);
        else             seg = $urandom_range(30, 150);
        out_ch.ready <= 1'b0;
        repeat (seg) @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: every accepted output item against the oldest due point
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_points
    hgli_pkg::result_t got;
    hgli_pkg::result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.payload;
      if (due_points.size() == 0) begin
        report_mismatch($sformatf("point t=%0d v=%0d arrived with none due",
                                  got.out_time, got.out_value));
      end else begin
        want = due_points.pop_front();
        if (got.out_time !== want.out_time)
          report_mismatch($sformatf("point %0d out_time %0d, want %0d",
                                    points_checked, got.out_time, want.out_time));
        if (got.out_value !== want.out_value)
          report_mismatch($sformatf("point %0d (t=%0d) out_value %0d, want %0d",
                                    points_checked, want.out_time, got.out_value,
                                    want.out_value));
        if (got.was_interpolated !== want.was_interpolated)
          report_mismatch($sformatf("point %0d was_interpolated %b, want %b",
                                    points_checked, got.was_interpolated,
                                    want.was_interpolated));
        if (got.buffer_overflow !== want.buffer_overflow)
          report_mismatch($sformatf("point %0d buffer_overflow %b, want %b",
                                    points_checked, got.buffer_overflow,
                                    want.buffer_overflow));
        if (got.run_last !== want.run_last)
          report_mismatch($sformatf("point %0d run_last %b, want %b",
                                    points_checked, got.run_last, want.run_last));
        points_checked++;
      end
    end
  end

  // Watchdog: too long without any item moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] ERROR stalled for %0d cycles, %0d points still due",
               $time, quiet_cycles, due_points.size());
      $display("hold_gap_linear_interpolator: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Field extremes, saturation both ways, zero span, backwards times,
  // end of stream with and without held times, plain interpolation.
  task automatic test_directed_corners();
    send_sample(32'sd0, RESET_V, 1'b0);          // repeat of the reset anchor
    send_sample(S32_MIN, RESET_V, 1'b0);         // held, time far in the past
    send_sample(32'sd10, S32_MAX, 1'b0);         // flush, extrapolation clips low
    send_sample(32'sd20, S32_MAX, 1'b0);
    send_sample(32'sd30, S32_MAX, 1'b0);
    send_sample(32'sd10, 32'sd0, 1'b0);          // zero span: held get anchor value
    send_sample(S32_MAX, 32'sd0, 1'b0);
    send_sample(32'sd40, 32'sd0, 1'b1);          // eos on a repeat flushes anyway
    send_sample(S32_MIN, S32_MIN, 1'b0);
    send_sample(S32_MAX, S32_MIN, 1'b0);         // widest time span
    send_sample(32'sd0, S32_MAX, 1'b1);          // widest value span, clips high
    send_sample(32'sd5, S32_MAX, 1'b1);          // eos with nothing held
    send_sample(32'sd6, -32'sd1, 1'b0);
    send_sample(32'sd7, -32'sd1, 1'b0);
    send_sample(32'sd9, -32'sd1, 1'b0);
    send_sample(32'sd11, 32'sh0001_0000, 1'b0);  // ordinary truncating divide
    send_sample(32'sd20, 32'sh0001_0000, 1'b0);
    send_sample(32'sd15, 32'sh0002_0000, 1'b0);  // held time beyond new sample
    send_sample(32'sd16, 32'sh0002_0000, 1'b0);
    send_sample(32'sd3, -32'sh0003_0000, 1'b0);  // negative time span
  endtask

  // Fill the buffer, push repeats past it, then flush a full buffer by a
  // distinct sample and once more by end of stream.
  task automatic test_buffer_full();
    logic signed [31:0] hold_v;
    stamp  = anchor_t;
    hold_v = anchor_v;
    for (int unsigned k = 0; k < DEPTH + 2; k++)
      send_sample(next_stamp(), hold_v, 1'b0);
    send_sample(next_stamp(), distinct_value(), 1'b0);
    hold_v = anchor_v;
    for (int unsigned k = 0; k < DEPTH + 1; k++)
      send_sample(next_stamp(), hold_v, 1'b0);
    send_sample(next_stamp(), hold_v, 1'b1);
  endtask

  // Sink holds off for a long stretch while samples keep coming, so the
  // output register fills and the input side stalls.
  task automatic test_output_backpressure();
    hold_off_len = PRESSURE_CYCLES;
    in_ch.valid <= 1'b0;
    while (!sink_holding) @(posedge clk);
    for (int unsigned k = 0; k < 12; k++) begin
      if (k % 3 == 0) send_sample(next_stamp(), anchor_v, 1'b0);
      send_sample(next_stamp(), distinct_value(), 1'b0);
    end
  endtask

  // One hold run: repeats with a few noise items mixed in, closed by a
  // distinct sample, a zero-span sample or an end of stream.
  task automatic hold_run(input int unsigned n_held);
    int unsigned r;
    for (int unsigned k = 0; k < n_held; k++) begin
      if ($urandom_range(0, 19) == 0)
        send_sample($signed($urandom()), random_value(), 1'($urandom_range(0, 1)));
      else
        send_sample(next_stamp(), anchor_v, 1'b0);
    end
    r = $urandom_range(0, 99);
    if (r < 10 && held_n != 0)
      send_sample(anchor_t, distinct_value(), 1'b0);
    else if (r < 25)
      send_sample(next_stamp(), ($urandom_range(0, 1) != 0) ? anchor_v : random_value(),
                  1'b1);
    else
      send_sample(next_stamp(), distinct_value(), 1'b0);
  endtask

  // Mostly short runs, some long, a few that overrun the buffer
  task automatic test_random_runs();
    int unsigned r;
    int unsigned n_held;
    int unsigned run_idx;
    run_idx = 0;
    while (samples_sent < ITEM_TARGET) begin
      src_gapless = (run_idx % 5 == 3);
      r = $urandom_range(0, 99);
      if (r < 50)      n_held = $urandom_range(0, 3);
      else if (r < 80) n_held = $urandom_range(4, 12);
      else if (r < 95) n_held = $urandom_range(13, DEPTH - 1);
      else             n_held = $urandom_range(DEPTH, DEPTH + 2);
      hold_run(n_held);
      run_idx++;
    end
    src_gapless = 1'b0;
  endtask

  // Final end of stream so no held time is left inside the block
  task automatic test_final_flush();
    send_sample(next_stamp(), anchor_v, 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_sequence
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    rst_n         <= 1'b0;
    error_count     = 0;
    samples_sent    = 0;
    points_checked  = 0;
    interp_points   = 0;
    overflow_points = 0;
    clipped_points  = 0;
    zero_span_runs  = 0;
    eos_flushes     = 0;
    src_gapless     = 1'b0;
    hold_off_len    = 0;
    sink_holding    = 1'b0;
    stamp           = 32'sd0;
    clear_interpolator();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_corners();
    test_buffer_full();
    test_output_backpressure();
    test_random_runs();
    test_final_flush();
    in_ch.valid <= 1'b0;

    // Watchdog covers a block that never delivers what is due
    while (due_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d samples, %0d points checked: %0d interpolated, %0d clipped,",
             samples_sent, points_checked, interp_points, clipped_points);
    $display("  %0d overflow repeats, %0d zero-span runs, %0d end-of-stream flushes.",
             overflow_points, zero_span_runs, eos_flushes);
    if (error_count == 0) begin
      $display("hold_gap_linear_interpolator: match");
    end else begin
      $display("hold_gap_linear_interpolator: mismatch");
    end
    $finish;
  end

endmodule
